@@ sv/bcg_pkg.sv @@
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types, register codes, state encodings and rounding helper of the
// bond cylinder glyph generator.
// ----------------------------------------------------------------------------
package bcg_pkg;

  // largest bond order that is expanded into cylinders
  localparam int unsigned MAX_ORDER = 7;

  // ceil(2^32 / 10), exact floor division by ten for values below 2^29
  localparam logic [28:0] RECIP_TEN = 29'd429496730;

  // 1.0 in Q1.30
  localparam logic [31:0] DIR_ONE = 32'h4000_0000;

  // last step of the shared multiplier sequence
  localparam logic [2:0] MUL_LAST = 3'd7;

  // register reset values
  localparam logic [23:0] RADIUS_RESET = 24'd8192;
  localparam logic [23:0] COLOR_RESET  = 24'h404040;

  // one bond, input beat
  typedef struct packed {
    logic signed [31:0] begin_x;
    logic signed [31:0] begin_y;
    logic signed [31:0] begin_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [2:0]         bond_order;
    logic [7:0]         begin_element;
    logic [7:0]         end_element;
    logic [23:0]        bond_index;
  } bond_t;

  // one cylinder, output beat
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        cyl_length;
    logic [23:0]        cyl_color;
    logic [24:0]        selection_id;
    logic               last;
  } glyph_t;

  // configuration registers
  typedef struct packed {
    logic        multi_bonds;
    logic        color_by_atom;
    logic [23:0] bond_radius;
    logic [23:0] bond_color;
    logic [23:0] atom_count;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_MULTI_BONDS   = 3'd0,
    CFG_COLOR_BY_ATOM = 3'd1,
    CFG_BOND_RADIUS   = 3'd2,
    CFG_BOND_COLOR    = 3'd3,
    CFG_ATOM_COUNT    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR_GO,
    S_DIR_WAIT,
    S_CROSS_GO,
    S_CROSS_WAIT,
    S_MUL,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SCALE,
    NS_SQUARE,
    NS_ROOT,
    NS_DLOAD,
    NS_DIVIDE
  } norm_state_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       norm_start;
    logic       norm_sel;
    logic       latch_dir;
    logic       latch_cross;
    logic       mul_run;
    logic [2:0] mul_step;
    logic       emit;
    logic [2:0] emit_j;
    logic       emit_k;
    logic       emit_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       norm_done;
    logic       spread;
    logic [2:0] order;
    logic       out_free;
  } dp_status_t;

  // round x / 2^sh to nearest, ties away from zero
  function automatic logic signed [65:0] round_shift(input logic signed [65:0] x,
                                                    input int unsigned sh);
    logic signed [65:0] half;
    half = 66'sd1 <<< (sh - 1);
    if (x[65]) begin
      half = half - 66'sd1;
    end
    return (x + half) >>> sh;
  endfunction

endpackage

@@ sv/bond_cylinder_glyph_gen.sv @@
// ----------------------------------------------------------------------------
// bond_cylinder_glyph_gen
// The first cylinder waits for the normalizer: prescale shifts, the 32-step
// square root and three divisions; a spread double or triple bond runs it
// again. An order-zero bond is captured and yields no cylinders.
// Throughput: one bond at a time, then one cylinder beat per cycle while
// the output register is free (glyph_stall low or no beat held).
// Reset (rst, synchronous): idle, no beat valid, registers at reset values.
// ----------------------------------------------------------------------------
module bond_cylinder_glyph_gen (
  input  logic             clk,
  input  logic             rst,
  input  logic             bond_valid,
  output logic             bond_stall,
  input  bcg_pkg::bond_t   bond,
  output logic             glyph_valid,
  input  logic             glyph_stall,
  output bcg_pkg::glyph_t  glyph,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  bcg_pkg::cfg_t       cfg;
  bcg_pkg::dp_cmd_t    cmd;
  bcg_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multi_bonds   <= 1'b0;
      cfg.color_by_atom <= 1'b0;
      cfg.bond_radius   <= bcg_pkg::RADIUS_RESET;
      cfg.bond_color    <= bcg_pkg::COLOR_RESET;
      cfg.atom_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bcg_pkg::cfg_reg_t'(cfg_index))
        bcg_pkg::CFG_MULTI_BONDS:   cfg.multi_bonds   <= cfg_data[0];
        bcg_pkg::CFG_COLOR_BY_ATOM: cfg.color_by_atom <= cfg_data[0];
        bcg_pkg::CFG_BOND_RADIUS:   cfg.bond_radius   <= cfg_data;
        bcg_pkg::CFG_BOND_COLOR:    cfg.bond_color    <= cfg_data;
        bcg_pkg::CFG_ATOM_COUNT:    cfg.atom_count    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .bond_valid (bond_valid),
    .bond_order (bond.bond_order),
    .bond_stall (bond_stall),
    .status     (status),
    .cmd        (cmd)
  );

  bcg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .bond        (bond),
    .cmd         (cmd),
    .status      (status),
    .glyph_valid (glyph_valid),
    .glyph_stall (glyph_stall),
    .glyph       (glyph)
  );

endmodule

@@ sv/bcg_norm.sv @@
// ----------------------------------------------------------------------------
// bcg_norm
// Iterative vector normalizer: prescale, sum of squares, bit-serial square
// root and restoring division, giving a Q1.30 unit vector and the length.
// ----------------------------------------------------------------------------
module bcg_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] a [3],
  output logic               done,
  output logic signed [31:0] u [3],
  output logic [31:0]        len
);

  bcg_pkg::norm_state_t state, state_next;

  logic [33:0] v [3];
  logic        neg [3];
  logic [1:0]  dn;
  logic [4:0]  up;
  logic [1:0]  idx;
  logic [63:0] acc;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [31:0] rem;
  logic [31:0] numlo;
  logic [31:0] q;
  logic [4:0]  cnt;

  logic        all_zero;
  logic        any_big;
  logic        any_norm;
  logic [61:0] sq;
  logic [63:0] root_sum;
  logic        root_ge;
  logic [61:0] num;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        div_ge;
  logic [31:0] rem_next;
  logic [31:0] q_full;
  logic [31:0] q_cl;
  logic [34:0] len_up;
  logic [31:0] len_calc;

  // scaling tests on the largest magnitude
  assign all_zero = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
  assign any_big  = |{v[0][33:31], v[1][33:31], v[2][33:31]};
  assign any_norm = |{v[0][33:30], v[1][33:30], v[2][33:30]};

  // one square per cycle
  assign sq = v[idx][30:0] * v[idx][30:0];

  // square root step
  assign root_sum = root + bitv;
  assign root_ge  = acc >= root_sum;

  // rounded numerator and division step
  assign num      = {1'b0, v[idx][30:0], 30'b0} + 62'(root[31:1]);
  assign trial    = {rem, numlo[31]};
  assign div_ge   = trial >= {1'b0, root[31:0]};
  assign diff     = trial - {1'b0, root[31:0]};
  assign rem_next = div_ge ? diff[31:0] : trial[31:0];
  assign q_full   = {q[30:0], div_ge};
  assign q_cl     = (q_full > bcg_pkg::DIR_ONE) ? bcg_pkg::DIR_ONE : q_full;

  // undo the prescale on the length, saturating
  assign len_up = {3'b0, root[31:0]} << dn;
  always_comb begin
    if (dn != 2'd0) begin
      len_calc = (|len_up[34:32]) ? '1 : len_up[31:0];
    end else begin
      len_calc = root[31:0] >> up;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcg_pkg::NS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bcg_pkg::NS_IDLE: begin
        if (start && !all_zero) state_next = bcg_pkg::NS_SCALE;
      end
      bcg_pkg::NS_SCALE: begin
        if (!any_big && any_norm) state_next = bcg_pkg::NS_SQUARE;
      end
      bcg_pkg::NS_SQUARE: begin
        if (idx == 2'd2) state_next = bcg_pkg::NS_ROOT;
      end
      bcg_pkg::NS_ROOT: begin
        if (bitv[0]) state_next = bcg_pkg::NS_DLOAD;
      end
      bcg_pkg::NS_DLOAD: begin
        state_next = bcg_pkg::NS_DIVIDE;
      end
      bcg_pkg::NS_DIVIDE: begin
        if (cnt == 5'd31) begin
          state_next = (idx == 2'd2) ? bcg_pkg::NS_IDLE : bcg_pkg::NS_DLOAD;
        end
      end
      default: state_next = bcg_pkg::NS_IDLE;
    endcase
  end

  // done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == bcg_pkg::NS_IDLE && start && all_zero) ||
              (state == bcg_pkg::NS_DIVIDE && cnt == 5'd31 && idx == 2'd2);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      bcg_pkg::NS_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            v[i]   <= a[i][33] ? 34'(-a[i]) : 34'(a[i]);
            neg[i] <= a[i][33];
          end
          dn  <= '0;
          up  <= '0;
          idx <= '0;
          acc <= '0;
          if (all_zero) begin
            for (int i = 0; i < 3; i++) begin
              u[i] <= '0;
            end
            len <= '0;
          end
        end
      end
      bcg_pkg::NS_SCALE: begin
        if (any_big) begin
          for (int i = 0; i < 3; i++) begin
            v[i] <= v[i] >> 1;
          end
          dn <= dn + 2'd1;
        end else if (!any_norm) begin
          for (int i = 0; i < 3; i++) begin
            v[i] <= v[i] << 1;
          end
          up <= up + 5'd1;
        end
      end
      bcg_pkg::NS_SQUARE: begin
        acc <= acc + 64'(sq);
        if (idx == 2'd2) begin
          idx  <= '0;
          root <= '0;
          bitv <= 64'h4000_0000_0000_0000;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      bcg_pkg::NS_ROOT: begin
        if (root_ge) begin
          acc  <= acc - root_sum;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      bcg_pkg::NS_DLOAD: begin
        rem   <= {2'b0, num[61:32]};
        numlo <= num[31:0];
        q     <= '0;
        cnt   <= '0;
      end
      bcg_pkg::NS_DIVIDE: begin
        rem   <= rem_next;
        numlo <= numlo << 1;
        q     <= q_full;
        cnt   <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          u[idx] <= neg[idx] ? -$signed(q_cl) : $signed(q_cl);
          if (idx == 2'd2) begin
            len <= len_calc;
          end else begin
            idx <= idx + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/bcg_dp.sv @@
// ----------------------------------------------------------------------------
// bcg_dp
// Datapath: bond capture, normalizer, shared multiplier for spacing and
// quarter offsets, and the output register for cylinder beats.
// ----------------------------------------------------------------------------
module bcg_dp (
  input  logic                clk,
  input  logic                rst,
  input  bcg_pkg::cfg_t       cfg,
  input  bcg_pkg::bond_t      bond,
  input  bcg_pkg::dp_cmd_t    cmd,
  output bcg_pkg::dp_status_t status,
  output logic                glyph_valid,
  input  logic                glyph_stall,
  output bcg_pkg::glyph_t     glyph
);

  logic signed [31:0] mid [3];
  logic signed [32:0] d [3];
  logic [2:0]         order;
  logic [7:0]         begin_el;
  logic [7:0]         end_el;
  logic [24:0]        sel_id;
  logic signed [31:0] dir [3];
  logic [31:0]        len;
  logic signed [31:0] p [3];
  logic [25:0]        dl;
  logic signed [31:0] qtr [3];
  logic signed [26:0] off1 [3];
  logic signed [26:0] off2 [3];
  logic signed [65:0] prod;

  logic signed [33:0] norm_in [3];
  logic               norm_done;
  logic signed [31:0] norm_u [3];
  logic [31:0]        norm_len;

  logic [28:0]        rad26;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_next;
  logic signed [65:0] rs32;
  logic signed [65:0] rs31;
  logic signed [65:0] rs30;
  logic               spread;
  logic signed [26:0] off_sel [3];
  bcg_pkg::glyph_t    beat;

  // normalizer operand: bond vector or the cross product of its unit direction with z
  always_comb begin
    if (cmd.norm_sel) begin
      norm_in[0] = 34'(dir[1]);
      norm_in[1] = -34'(dir[0]);
      norm_in[2] = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        norm_in[i] = 34'(d[i]);
      end
    end
  end

  bcg_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .a     (norm_in),
    .done  (norm_done),
    .u     (norm_u),
    .len   (norm_len)
  );

  // bond capture and normalizer results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mid[0] <= 32'((33'(bond.begin_x) + 33'(bond.end_x)) >>> 1);
      mid[1] <= 32'((33'(bond.begin_y) + 33'(bond.end_y)) >>> 1);
      mid[2] <= 32'((33'(bond.begin_z) + 33'(bond.end_z)) >>> 1);
      d[0]   <= 33'(bond.end_x) - 33'(bond.begin_x);
      d[1]   <= 33'(bond.end_y) - 33'(bond.begin_y);
      d[2]   <= 33'(bond.end_z) - 33'(bond.begin_z);
      order  <= (32'(bond.bond_order) > bcg_pkg::MAX_ORDER) ?
                3'(bcg_pkg::MAX_ORDER) : bond.bond_order;
      begin_el <= bond.begin_element;
      end_el   <= bond.end_element;
      sel_id   <= 25'(cfg.atom_count) + 25'(bond.bond_index);
    end
    if (cmd.latch_dir) begin
      dir <= norm_u;
      len <= norm_len;
    end
    if (cmd.latch_cross) begin
      p <= norm_u;
    end
  end

  // shared multiplier operands
  assign rad26 = {cfg.bond_radius, 4'b0} + {1'b0, cfg.bond_radius, 3'b0}
               + {3'b0, cfg.bond_radius, 1'b0} + 29'd5;

  always_comb begin
    unique case (cmd.mul_step)
      3'd0: begin
        mul_a = {4'b0, rad26};
        mul_b = {4'b0, bcg_pkg::RECIP_TEN};
      end
      3'd1: begin
        mul_a = 33'(dir[0]);
        mul_b = {1'b0, len};
      end
      3'd2: begin
        mul_a = 33'(dir[1]);
        mul_b = {1'b0, len};
      end
      3'd3: begin
        mul_a = 33'(dir[2]);
        mul_b = {1'b0, len};
      end
      3'd4: begin
        mul_a = 33'(p[0]);
        mul_b = {7'b0, dl};
      end
      3'd5: begin
        mul_a = 33'(p[1]);
        mul_b = {7'b0, dl};
      end
      3'd6: begin
        mul_a = 33'(p[2]);
        mul_b = {7'b0, dl};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign rs32 = bcg_pkg::round_shift(prod, 32);
  assign rs31 = bcg_pkg::round_shift(prod, 31);
  assign rs30 = bcg_pkg::round_shift(prod, 30);

  // product register, stored one step later
  always_ff @(posedge clk) begin
    if (cmd.mul_run) begin
      prod <= prod_next;
      unique case (cmd.mul_step)
        3'd1: dl <= prod[57:32];
        3'd2: qtr[0] <= rs32[31:0];
        3'd3: qtr[1] <= rs32[31:0];
        3'd4: qtr[2] <= rs32[31:0];
        3'd5: begin
          off1[0] <= rs31[26:0];
          off2[0] <= rs30[26:0];
        end
        3'd6: begin
          off1[1] <= rs31[26:0];
          off2[1] <= rs30[26:0];
        end
        3'd7: begin
          off1[2] <= rs31[26:0];
          off2[2] <= rs30[26:0];
        end
        default: begin
        end
      endcase
    end
  end

  // spacing offset of cylinder j
  assign spread = cfg.multi_bonds && (order == 3'd2 || order == 3'd3);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!spread) begin
        off_sel[i] = '0;
      end else if (order == 3'd2) begin
        off_sel[i] = (cmd.emit_j == 3'd0) ? -off1[i] : off1[i];
      end else if (cmd.emit_j == 3'd0) begin
        off_sel[i] = -off2[i];
      end else if (cmd.emit_j == 3'd1) begin
        off_sel[i] = '0;
      end else begin
        off_sel[i] = off2[i];
      end
    end
  end

  // assemble one cylinder beat
  always_comb begin
    logic signed [31:0] cen [3];
    for (int i = 0; i < 3; i++) begin
      cen[i] = mid[i] + 32'(off_sel[i]);
      if (cfg.color_by_atom) begin
        cen[i] = cmd.emit_k ? (cen[i] + qtr[i]) : (cen[i] - qtr[i]);
      end
    end
    beat.center_x     = cen[0];
    beat.center_y     = cen[1];
    beat.center_z     = cen[2];
    beat.dir_x        = dir[0];
    beat.dir_y        = dir[1];
    beat.dir_z        = dir[2];
    beat.cyl_length   = cfg.color_by_atom ? (len >> 1) : len;
    beat.cyl_color    = cfg.color_by_atom ?
                        {16'b0, (cmd.emit_k ? end_el : begin_el)} : cfg.bond_color;
    beat.selection_id = sel_id;
    beat.last         = cmd.emit_last;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (cmd.emit) begin
      glyph_valid <= 1'b1;
    end else if (!glyph_stall) begin
      glyph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      glyph <= beat;
    end
  end

  assign status.norm_done = norm_done;
  assign status.spread    = spread;
  assign status.order     = order;
  assign status.out_free  = !glyph_valid || !glyph_stall;

endmodule

@@ sv/bcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcg_ctrl
// Controller: accepts a bond, sequences one or two normalizations (the second
// only for a spread bond) and the multiplier steps, then walks cylinders and
// halves to emit beats.
module bcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  bcg_pkg::cfg_t       cfg,
  input  logic                bond_valid,
  input  logic [2:0]          bond_order,
  output logic                bond_stall,
  input  bcg_pkg::dp_status_t status,
  output bcg_pkg::dp_cmd_t    cmd
);

  bcg_pkg::ctrl_state_t state, state_next;
  logic [2:0] mul_step, mul_step_next;
  logic [2:0] cyl_j, cyl_j_next;
  logic       half_k, half_k_next;
  logic       is_last;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bcg_pkg::S_IDLE;
      mul_step <= '0;
      cyl_j    <= '0;
      half_k   <= 1'b0;
    end else begin
      state    <= state_next;
      mul_step <= mul_step_next;
      cyl_j    <= cyl_j_next;
      half_k   <= half_k_next;
    end
  end

  assign is_last = (cyl_j == status.order - 3'd1) && (half_k == cfg.color_by_atom);

  // next state and commands
  always_comb begin
    state_next    = state;
    mul_step_next = mul_step;
    cyl_j_next    = cyl_j;
    half_k_next   = half_k;
    bond_stall    = 1'b1;
    cmd           = '0;
    cmd.mul_step  = mul_step;
    cmd.emit_j    = cyl_j;
    cmd.emit_k    = half_k;
    cmd.emit_last = is_last;
    unique case (state)
      bcg_pkg::S_IDLE: begin
        bond_stall = 1'b0;
        if (bond_valid) begin
          cmd.capture = 1'b1;
          if (bond_order != 3'd0) state_next = bcg_pkg::S_DIR_GO;
        end
      end
      bcg_pkg::S_DIR_GO: begin
        cmd.norm_start = 1'b1;
        state_next     = bcg_pkg::S_DIR_WAIT;
      end
      bcg_pkg::S_DIR_WAIT: begin
        if (status.norm_done) begin
          cmd.latch_dir = 1'b1;
          mul_step_next = '0;
          state_next    = status.spread ? bcg_pkg::S_CROSS_GO : bcg_pkg::S_MUL;
        end
      end
      bcg_pkg::S_CROSS_GO: begin
        cmd.norm_start = 1'b1;
        cmd.norm_sel   = 1'b1;
        state_next     = bcg_pkg::S_CROSS_WAIT;
      end
      bcg_pkg::S_CROSS_WAIT: begin
        cmd.norm_sel = 1'b1;
        if (status.norm_done) begin
          cmd.latch_cross = 1'b1;
          mul_step_next   = '0;
          state_next      = bcg_pkg::S_MUL;
        end
      end
      bcg_pkg::S_MUL: begin
        cmd.mul_run = 1'b1;
        if (mul_step == bcg_pkg::MUL_LAST) begin
          cyl_j_next  = '0;
          half_k_next = 1'b0;
          state_next  = bcg_pkg::S_EMIT;
        end else begin
          mul_step_next = mul_step + 3'd1;
        end
      end
      bcg_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (is_last) begin
            state_next = bcg_pkg::S_IDLE;
          end else if (half_k != cfg.color_by_atom) begin
            half_k_next = 1'b1;
          end else begin
            half_k_next = 1'b0;
            cyl_j_next  = cyl_j + 3'd1;
          end
        end
      end
      default: state_next = bcg_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a beat is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("beat emitted into a busy output register");

  // a bond with cylinders to draw holds off the next one
  assert property (@(posedge clk) disable iff (rst)
    (bond_valid && !bond_stall && bond_order != 3'd0) |=> bond_stall)
    else $error("new bond taken while one is in work");

  // the final beat of a bond frees the input
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> !bond_stall)
    else $error("input not released after the final beat");

  // a normalizer start is always followed by one of its wait states
  assert property (@(posedge clk) disable iff (rst)
    cmd.norm_start |=> (state == bcg_pkg::S_DIR_WAIT || state == bcg_pkg::S_CROSS_WAIT))
    else $error("normalizer start without a wait state");
`endif

endmodule
